// ===== design/dcbf_pkg.sv =====
// Shared types and constants of the distance cutoff bond finder.
`timescale 1ns / 1ps

package dcbf_pkg;

    // Store size and derived widths
    localparam int MAX_ATOMS = 64;
    localparam int IDX_W     = $clog2(MAX_ATOMS);
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

    // Coordinate and distance arithmetic widths
    localparam int COORD_W = 25;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int LIMIT_W = 32;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOND_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = CFG_IDX_W'(1);

    // Reset values of the limits: 1.58 A and 1.45 A, squared, in square milliangstrom
    localparam logic [LIMIT_W-1:0] BOND_LIMIT_RST  = LIMIT_W'(2496400);
    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = LIMIT_W'(2102500);

    // One atom as held in a cell
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      carbon;
    } atom_t;

    // Comparison token carried alongside the distance pipeline
    typedef struct packed {
        logic             live;   // token present in this stage
        logic             cand;   // stored atom index is below the new index
        logic             eos;    // last position of the scan
        logic             cc;     // both atoms are carbon
        logic [IDX_W-1:0] idx;    // index of the stored atom
    } tok_t;

endpackage

// ===== design/distance_cutoff_bond_finder_unit.sv =====
// Top level of the distance cutoff bond finder: atom ring, scan control, bond output.
`timescale 1ns / 1ps

//  Channel   Direction  Ports
//  input     in         s_valid, s_ready, s_pos_x/y/z, s_is_carbon, s_new_molecule
//  result    out        m_valid, m_ready, m_earlier_atom, m_later_atom,
//                       m_short_carbon_pair, m_last_bond
//  config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
//  An atom that lands at index 0, or is dropped on a full store, needs no scan.
//  Any other atom rotates the whole ring of MAX_ATOMS cells past one distance unit,
//  one stored atom a cycle while the output does not stall, then drains the 3-stage pipeline.
//  A result waiting in the output register that is not taken freezes ring and pipeline.
//  Reset empties the store (count to zero) and loads the default limits; cells are not cleared.
module distance_cutoff_bond_finder_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [dcbf_pkg::COORD_W-1:0]  s_pos_x,
    input  logic signed [dcbf_pkg::COORD_W-1:0]  s_pos_y,
    input  logic signed [dcbf_pkg::COORD_W-1:0]  s_pos_z,
    input  logic                                 s_is_carbon,
    input  logic                                 s_new_molecule,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dcbf_pkg::IDX_W-1:0]           m_earlier_atom,
    output logic [dcbf_pkg::IDX_W-1:0]           m_later_atom,
    output logic                                 m_short_carbon_pair,
    output logic                                 m_last_bond,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dcbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcbf_pkg::LIMIT_W-1:0]         cfg_data
);

    localparam int MAXA = dcbf_pkg::MAX_ATOMS;
    localparam int IW   = dcbf_pkg::IDX_W;
    localparam int NW   = dcbf_pkg::CNT_W;
    localparam int SW   = dcbf_pkg::SUM_W;
    localparam int LW   = dcbf_pkg::LIMIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   scan_reg, scan_next;
    logic [IW-1:0]   me_reg, me_next;
    dcbf_pkg::atom_t hold_reg, hold_next;

    logic [LW-1:0]   bond_lim_reg, bond_lim_next;
    logic [LW-1:0]   short_lim_reg, short_lim_next;

    logic            pend_vld_reg, pend_vld_next;
    logic [IW-1:0]   pend_idx_reg, pend_idx_next;
    logic            pend_sh_reg, pend_sh_next;

    logic            out_vld_reg, out_vld_next;
    logic [IW-1:0]   out_earlier_reg, out_earlier_next;
    logic [IW-1:0]   out_later_reg, out_later_next;
    logic            out_sh_reg, out_sh_next;
    logic            out_last_reg, out_last_next;

    dcbf_pkg::atom_t cell_q [MAXA];
    dcbf_pkg::atom_t in_atom;
    dcbf_pkg::atom_t wr_atom;
    dcbf_pkg::tok_t  tok0, tok3;
    logic [SW-1:0]   dist_sq;
    logic [NW-1:0]   eff_cnt;
    logic [IW-1:0]   wr_idx;
    logic            wr_go;
    logic            adv;
    logic            shift_en;
    logic            acc_in;
    logic            bond_hit;
    logic            short_hit;
    logic            scan_end;

    assign in_atom = '{x: s_pos_x, y: s_pos_y, z: s_pos_z, carbon: s_is_carbon};

    // Handshakes; the scan moves whenever the output register can take an item
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign acc_in    = s_valid && s_ready;
    assign adv       = !out_vld_reg || m_ready;
    assign shift_en  = (state_reg == ST_SCAN) && adv;
    assign scan_end  = (scan_reg == IW'(MAXA - 1));
    assign eff_cnt   = s_new_molecule ? '0 : cnt_reg;

    // Ring of cells: cell k takes from cell k+1, cell 0 is the head
    for (genvar k = 0; k < MAXA; k++) begin : g_ring
        localparam int NXT = (k + 1) % MAXA;
        dcbf_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .nbr_in   (cell_q[NXT]),
            .wr_en    (wr_go && (wr_idx == IW'(k))),
            .wr_data  (wr_atom),
            .atom_out (cell_q[k])
        );
    end

    // Token for the atom at the head of the ring
    always_comb begin
        tok0.live = (state_reg == ST_SCAN);
        tok0.cand = (scan_reg < me_reg);
        tok0.eos  = scan_end;
        tok0.cc   = cell_q[0].carbon && hold_reg.carbon;
        tok0.idx  = scan_reg;
    end

    dcbf_dist_pipe u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .tok_in    (tok0),
        .head_atom (cell_q[0]),
        .new_atom  (hold_reg),
        .tok_out   (tok3),
        .dist_sq   (dist_sq)
    );

    // Limit tests on the finished sum
    assign bond_hit  = adv && tok3.live && tok3.cand && (dist_sq < SW'(bond_lim_reg));
    assign short_hit = tok3.cc && (dist_sq < SW'(short_lim_reg));

    // Scan sequencer and store bookkeeping
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        me_next    = me_reg;
        hold_next  = hold_reg;
        wr_go      = 1'b0;
        wr_idx     = me_reg;
        wr_atom    = hold_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc_in) begin
                    cnt_next = eff_cnt;
                    if (eff_cnt == '0) begin
                        // first atom of a molecule: no partners
                        wr_go    = 1'b1;
                        wr_idx   = '0;
                        wr_atom  = in_atom;
                        cnt_next = NW'(1);
                    end else if (eff_cnt != NW'(MAXA)) begin
                        hold_next  = in_atom;
                        me_next    = IW'(eff_cnt);
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    scan_next = scan_reg + IW'(1);
                    if (scan_end) begin
                        // ring is back in place: store the new atom
                        wr_go      = 1'b1;
                        cnt_next   = NW'(me_reg) + NW'(1);
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (adv && tok3.live && tok3.eos) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Bond hand-off: one bond held back until the next one shows it was not the last
    always_comb begin
        pend_vld_next    = pend_vld_reg;
        pend_idx_next    = pend_idx_reg;
        pend_sh_next     = pend_sh_reg;
        out_vld_next     = out_vld_reg && !m_ready;
        out_earlier_next = out_earlier_reg;
        out_later_next   = out_later_reg;
        out_sh_next      = out_sh_reg;
        out_last_next    = out_last_reg;
        if (bond_hit) begin
            if (pend_vld_reg) begin
                out_vld_next     = 1'b1;
                out_earlier_next = pend_idx_reg;
                out_later_next   = me_reg;
                out_sh_next      = pend_sh_reg;
                out_last_next    = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = tok3.idx;
            pend_sh_next  = short_hit;
        end else if (adv && tok3.live && tok3.eos && pend_vld_reg) begin
            out_vld_next     = 1'b1;
            out_earlier_next = pend_idx_reg;
            out_later_next   = me_reg;
            out_sh_next      = pend_sh_reg;
            out_last_next    = 1'b1;
            pend_vld_next    = 1'b0;
        end
    end

    // Configuration decode
    always_comb begin
        bond_lim_next  = bond_lim_reg;
        short_lim_next = short_lim_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dcbf_pkg::CFG_BOND_LIMIT:  bond_lim_next  = cfg_data;
                dcbf_pkg::CFG_SHORT_LIMIT: short_lim_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            bond_lim_reg  <= dcbf_pkg::BOND_LIMIT_RST;
            short_lim_reg <= dcbf_pkg::SHORT_LIMIT_RST;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            pend_vld_reg  <= pend_vld_next;
            out_vld_reg   <= out_vld_next;
            bond_lim_reg  <= bond_lim_next;
            short_lim_reg <= short_lim_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        me_reg          <= me_next;
        hold_reg        <= hold_next;
        pend_idx_reg    <= pend_idx_next;
        pend_sh_reg     <= pend_sh_next;
        out_earlier_reg <= out_earlier_next;
        out_later_reg   <= out_later_next;
        out_sh_reg      <= out_sh_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid             = out_vld_reg;
    assign m_earlier_atom      = out_earlier_reg;
    assign m_later_atom        = out_later_reg;
    assign m_short_carbon_pair = out_sh_reg;
    assign m_last_bond         = out_last_reg;

    // Checks
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("bond still held back while idle");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(MAXA))
        else $error("atom count above store size");

    a_end_not_bond: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok3.live && tok3.eos) |-> !tok3.cand)
        else $error("end-of-scan position taken as a bond partner");

    a_scan_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_SCAN) |-> (scan_reg == '0 && !pend_vld_reg))
        else $error("scan started from a dirty position");

endmodule

// ===== design/dcbf_cell.sv =====
// One storage cell of the rotating atom ring.
`timescale 1ns / 1ps

module dcbf_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  dcbf_pkg::atom_t nbr_in,
    input  logic            wr_en,
    input  dcbf_pkg::atom_t wr_data,
    output dcbf_pkg::atom_t atom_out
);

    dcbf_pkg::atom_t atom_reg;
    dcbf_pkg::atom_t atom_next;

    // A write wins over the shift; after a full turn the shifted value is the old entry anyway
    always_comb begin
        atom_next = atom_reg;
        if (wr_en) begin
            atom_next = wr_data;
        end else if (shift_en) begin
            atom_next = nbr_in;
        end
    end

    always_ff @(posedge aclk) begin
        atom_reg <= atom_next;
    end

    assign atom_out = atom_reg;

endmodule

// ===== design/dcbf_dist_pipe.sv =====
// Three-stage squared distance pipeline: differences, squares, sum.
`timescale 1ns / 1ps

module dcbf_dist_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  dcbf_pkg::tok_t                 tok_in,
    input  dcbf_pkg::atom_t                head_atom,
    input  dcbf_pkg::atom_t                new_atom,
    output dcbf_pkg::tok_t                 tok_out,
    output logic [dcbf_pkg::SUM_W-1:0]     dist_sq
);

    localparam int DW = dcbf_pkg::DIFF_W;
    localparam int CW = dcbf_pkg::COORD_W;
    localparam int QW = dcbf_pkg::SQ_W;
    localparam int SW = dcbf_pkg::SUM_W;

    dcbf_pkg::tok_t tok1_reg, tok2_reg, tok3_reg;

    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;
    logic [CW-1:0]        mx, my, mz;
    logic [QW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [QW-1:0]        sqx_next, sqy_next, sqz_next;
    logic [SW-1:0]        sum_reg, sum_next;

    // Stage 1: coordinate differences, sign-extended by one bit
    always_comb begin
        dx_next = {new_atom.x[CW-1], new_atom.x} - {head_atom.x[CW-1], head_atom.x};
        dy_next = {new_atom.y[CW-1], new_atom.y} - {head_atom.y[CW-1], head_atom.y};
        dz_next = {new_atom.z[CW-1], new_atom.z} - {head_atom.z[CW-1], head_atom.z};
    end

    // Stage 2: magnitudes fit CW bits, then square
    always_comb begin
        mx = dx_reg[DW-1] ? CW'(-dx_reg) : CW'(dx_reg);
        my = dy_reg[DW-1] ? CW'(-dy_reg) : CW'(dy_reg);
        mz = dz_reg[DW-1] ? CW'(-dz_reg) : CW'(dz_reg);
        sqx_next = QW'(mx) * QW'(mx);
        sqy_next = QW'(my) * QW'(my);
        sqz_next = QW'(mz) * QW'(mz);
    end

    // Stage 3: sum of squares
    always_comb begin
        sum_next = SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
    end

    // Token flow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
        end else if (adv) begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok2_reg;
        end
    end

    // Arithmetic payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
            sum_reg <= sum_next;
        end
    end

    assign tok_out = tok3_reg;
    assign dist_sq = sum_reg;

endmodule
